// File: design/blcta_pkg.sv
`default_nettype none
package blcta_pkg;
  localparam int unsigned LineSize    = 64;
  localparam int unsigned Ways        = 4;
  localparam int unsigned Banks       = 4;
  localparam int unsigned SetsPerBank = 64;
  localparam int unsigned AddrBits    = 32;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_INVAL = 2'd2,
    MODE_CLEAN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LOOK  = 2'd1,
    ST_CLEAN = 2'd2
  } state_e;
endpackage
`default_nettype wire

// File: design/banked_lru_cache_tag_array.sv
// channel | direction | signals
// in      | input     | in_valid_i/in_ready_o, mode_i, address_i, full_line_i
// out     | output    | out_valid_o/out_ready_i, hit_o .. last_o
// cfg     | input     | cfg_we_i, cfg_wdata_i (bypass)
// each item first reads its set row from the state memory into a register,
// then decides and writes the row back; clean set gives one result for each
// dirty way, or a single one if none is dirty. one item is in flight at a
// time, so no forwarding is needed. a result waits in the output register
// while out_ready_i is low, and the next result is held back until it leaves.
// after reset the state memory is swept clear, one row a cycle, during which
// no item is taken.
`default_nettype none
module banked_lru_cache_tag_array #(
  parameter int unsigned LINE_SIZE     = blcta_pkg::LineSize,
  parameter int unsigned WAYS          = blcta_pkg::Ways,
  parameter int unsigned BANKS         = blcta_pkg::Banks,
  parameter int unsigned SETS_PER_BANK = blcta_pkg::SetsPerBank,
  parameter int unsigned ADDR_BITS     = blcta_pkg::AddrBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] address_i,
  input  wire logic        full_line_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [1:0]       way_o,
  output logic [1:0]       bank_o,
  output logic [5:0]       set_idx_o,
  output logic             evicted_o,
  output logic             writeback_o,
  output logic [31:0]      writeback_address_o,
  output logic             fetch_needed_o,
  output logic             bypassed_o,
  output logic             misaligned_o,
  output logic             last_o
);
  localparam int unsigned OffW  = $clog2(LINE_SIZE);
  localparam int unsigned BankW = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int unsigned BankB = $clog2(BANKS);
  localparam int unsigned SetW  = (SETS_PER_BANK > 1) ? $clog2(SETS_PER_BANK) : 1;
  localparam int unsigned SetB  = $clog2(SETS_PER_BANK);
  localparam int unsigned TagW  = ADDR_BITS - OffW - BankB - SetB;
  localparam int unsigned Rows  = BANKS * SETS_PER_BANK;
  localparam int unsigned RowW  = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned WayW  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RankW = WayW;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [RankW-1:0] rank;
    logic [TagW-1:0]  tag;
  } entry_t;
  typedef entry_t [WAYS-1:0] row_t;

  // state memory, one row per set with all ways
  row_t mem_q [Rows];
  row_t rd_q;

  blcta_pkg::state_e state_q, state_d;
  logic              bypass_q;
  logic [RowW:0]     clr_q;
  logic [1:0]        mode_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic              full_q;
  row_t              row_q;
  logic              row_own_q;

  logic              ov_q;
  logic              hit_q, ev_q, wb_q, fe_q, by_q, mis_q, last_q;
  logic [1:0]        way_q;
  logic [1:0]        obank_q;
  logic [5:0]        oset_q;
  logic [31:0]       wba_q;

  logic [ADDR_BITS-1:0] addr_i_m;
  logic [BankW-1:0]  bank_a;
  logic [SetW-1:0]   set_a;
  logic [RowW-1:0]   row_a;
  logic [BankW-1:0]  bank_q;
  logic [SetW-1:0]   set_q;
  logic [TagW-1:0]   tag_q;
  logic [RowW-1:0]   rowi_q;
  logic [RowW-1:0]   rd_a;

  logic              take, out_free, clearing;
  logic              we;
  logic [RowW-1:0]   wa;
  row_t              wd;
  row_t              cur, nrow;
  logic              emit, e_hit, e_ev, e_wb, e_fe, e_last;
  logic [WayW-1:0]   e_way;
  logic [TagW-1:0]   e_tag;

  assign addr_i_m = address_i[ADDR_BITS-1:0];
  assign clearing = ~clr_q[RowW];
  assign out_free = ~ov_q | out_ready_i;
  assign in_ready_o = (state_q == blcta_pkg::ST_IDLE) & ~clearing;
  assign take = in_valid_i & in_ready_o;

  // address fields of the held item and of the incoming item
  always_comb begin
    bank_q = '0;
    set_q  = '0;
    if (BankB > 0) bank_q = BankW'(addr_q >> OffW);
    if (SetB > 0)  set_q  = SetW'(addr_q >> (OffW + BankB));
    tag_q  = TagW'(addr_q >> (OffW + BankB + SetB));
    rowi_q = RowW'(32'(bank_q) * SETS_PER_BANK + 32'(set_q));
    bank_a = '0;
    set_a  = '0;
    if (BankB > 0) bank_a = BankW'(addr_i_m >> OffW);
    if (SetB > 0)  set_a  = SetW'(addr_i_m >> (OffW + BankB));
    row_a  = RowW'(32'(bank_a) * SETS_PER_BANK + 32'(set_a));
  end

  // read the incoming item's row when idle, else keep reading the held row
  assign rd_a = (state_q == blcta_pkg::ST_IDLE) ? row_a : rowi_q;

  // memory read and write
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[rd_a];
  end

  // decide, update row and build result
  always_comb begin
    logic misal, found;
    logic [WayW-1:0] fw, vw;
    logic anyinv;
    logic [RankW-1:0] old;
    logic oldv;
    cur = row_own_q ? row_q : rd_q;
    nrow = cur;
    emit = 1'b0; e_hit = 1'b0; e_ev = 1'b0; e_wb = 1'b0; e_fe = 1'b0;
    e_last = 1'b1; e_way = '0; e_tag = '0;
    we = 1'b0; wa = rowi_q; wd = cur;
    state_d = state_q;
    misal = (addr_q[OffW-1:0] != '0);
    found = 1'b0; fw = '0; anyinv = 1'b0; vw = '0; old = '0; oldv = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (cur[w].valid && cur[w].tag == tag_q) begin
        found = 1'b1; fw = WayW'(w);
      end
      if (!cur[w].valid) begin
        anyinv = 1'b1; vw = WayW'(w);
      end
    end
    if (!anyinv) begin
      vw = '0;
      for (int w = 1; w < WAYS; w++)
        if (cur[w].rank > cur[vw].rank) vw = WayW'(w);
    end
    if (clearing) begin
      we = 1'b1; wa = clr_q[RowW-1:0]; wd = '0;
    end
    unique case (state_q)
      blcta_pkg::ST_LOOK: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = blcta_pkg::ST_IDLE;
          if (bypass_q || (mode_q <= blcta_pkg::MODE_WRITE && misal)) begin
          end else if (mode_q == blcta_pkg::MODE_CLEAN) begin
            emit = 1'b0;
            state_d = blcta_pkg::ST_CLEAN;
          end else if (mode_q == blcta_pkg::MODE_INVAL) begin
            if (found) begin
              e_hit = 1'b1; e_way = fw; e_wb = cur[fw].dirty;
              for (int w = 0; w < WAYS; w++)
                if (WayW'(w) != fw && cur[w].valid && cur[w].rank > cur[fw].rank)
                  nrow[w].rank = cur[w].rank - 1'b1;
              nrow[fw] = '0;
              we = 1'b1; wd = nrow;
            end
          end else begin
            if (found) begin
              e_hit = 1'b1; e_way = fw;
            end else begin
              e_way = vw; e_ev = cur[vw].valid;
              e_wb = cur[vw].valid & cur[vw].dirty; e_tag = cur[vw].tag;
              e_fe = ~(mode_q == blcta_pkg::MODE_WRITE && full_q);
            end
            oldv = cur[e_way].valid;
            old = cur[e_way].rank;
            for (int w = 0; w < WAYS; w++)
              if (WayW'(w) != e_way && cur[w].valid && (!oldv || cur[w].rank < old)
                  && cur[w].rank != RankW'(WAYS - 1))
                nrow[w].rank = cur[w].rank + 1'b1;
            nrow[e_way].rank = '0;
            nrow[e_way].valid = 1'b1;
            if (found) begin
              if (mode_q == blcta_pkg::MODE_WRITE) nrow[e_way].dirty = 1'b1;
            end else begin
              nrow[e_way].dirty = (mode_q == blcta_pkg::MODE_WRITE);
              nrow[e_way].tag = tag_q;
            end
            we = 1'b1; wd = nrow;
          end
        end
      end
      blcta_pkg::ST_CLEAN: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = blcta_pkg::ST_IDLE;
          found = 1'b0;
          for (int w = WAYS - 1; w >= 0; w--)
            if (cur[w].valid && cur[w].dirty) begin
              found = 1'b1; fw = WayW'(w);
            end
          if (found) begin
            e_way = fw; e_wb = 1'b1; e_tag = cur[fw].tag;
            nrow[fw].dirty = 1'b0;
            we = 1'b1; wd = nrow;
            for (int w = 0; w < WAYS; w++)
              if (nrow[w].valid && nrow[w].dirty) begin
                e_last = 1'b0; state_d = blcta_pkg::ST_CLEAN;
              end
          end
        end
      end
      default: begin
        if (take) state_d = blcta_pkg::ST_LOOK;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= blcta_pkg::ST_IDLE;
      bypass_q  <= 1'b0;
      clr_q     <= '0;
      ov_q      <= 1'b0;
      row_own_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) bypass_q <= cfg_wdata_i;
      if (clearing) clr_q <= clr_q + 1'b1;
      if (emit) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      if (take) row_own_q <= 1'b0;
      else if (we && !clearing) row_own_q <= 1'b1;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    logic [63:0] rb;
    rb = ((64'(e_tag) * SETS_PER_BANK + 64'(set_q)) * BANKS + 64'(bank_q)) * LINE_SIZE;
    if (take) begin
      mode_q <= mode_i; addr_q <= addr_i_m; full_q <= full_line_i;
    end
    if (we && !clearing) row_q <= wd;
    if (emit) begin
      hit_q  <= e_hit;  way_q <= 2'(e_way); ev_q <= e_ev; wb_q <= e_wb;
      fe_q   <= e_fe;   last_q <= e_last;
      obank_q <= 2'(bank_q);
      oset_q  <= 6'(set_q);
      by_q   <= bypass_q;
      mis_q  <= ~bypass_q & (mode_q <= blcta_pkg::MODE_WRITE) &
                (addr_q[OffW-1:0] != '0);
      if (!e_wb) wba_q <= '0;
      else if (mode_q == blcta_pkg::MODE_INVAL)
        wba_q <= 32'({addr_q[ADDR_BITS-1:OffW], {OffW{1'b0}}});
      else wba_q <= rb[31:0];
    end
  end

  assign out_valid_o = ov_q;
  assign hit_o = hit_q;
  assign way_o = way_q;
  assign bank_o = obank_q;
  assign set_idx_o = oset_q;
  assign evicted_o = ev_q;
  assign writeback_o = wb_q;
  assign writeback_address_o = wba_q;
  assign fetch_needed_o = fe_q;
  assign bypassed_o = by_q;
  assign misaligned_o = mis_q;
  assign last_o = last_q;

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> !in_ready_o) else $error("item taken while busy");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free) else $error("result overwritten");
  a_no_item_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !take) else $error("item during clear");
endmodule
`default_nettype wire

// File: tb/tb_banked_lru_cache_tag_array.sv
`timescale 1ns / 1ps
module tb_banked_lru_cache_tag_array;

  typedef struct packed {
    logic        hit;
    logic [1:0]  way;
    logic [1:0]  bank;
    logic [5:0]  set_idx;
    logic        evicted;
    logic        writeback;
    logic [31:0] writeback_address;
    logic        fetch_needed;
    logic        bypassed;
    logic        misaligned;
    logic        last;
  } tag_result_t;

  typedef struct packed {
    blcta_pkg::mode_e mode;
    logic [31:0]      address;
    logic             full_line;
  } access_t;

  localparam int CycleLimit = 200000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i, cfg_wdata_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  mode_i;
  logic [31:0] address_i;
  logic        full_line_i;
  logic        out_valid_o, out_ready_i;
  logic        hit_o, evicted_o, writeback_o, fetch_needed_o;
  logic        bypassed_o, misaligned_o, last_o;
  logic [1:0]  way_o, bank_o;
  logic [5:0]  set_idx_o;
  logic [31:0] writeback_address_o;

  banked_lru_cache_tag_array u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i, .address_i, .full_line_i,
    .out_valid_o, .out_ready_i, .hit_o, .way_o, .bank_o, .set_idx_o,
    .evicted_o, .writeback_o, .writeback_address_o, .fetch_needed_o,
    .bypassed_o, .misaligned_o, .last_o
  );

  // cache state mirror
  logic        line_vld [256][4];
  logic        line_drt [256][4];
  logic [17:0] line_tg  [256][4];
  logic [1:0]  line_rk  [256][4];
  logic        bypass_q;

  access_t     pending_accesses[$];
  tag_result_t expected_results[$];
  int          errors, accepted, result_cnt, hit_cnt, evict_cnt, wb_cnt, cycles;
  int          send_gap, recv_stall;
  bit          no_idle;

  // clock
  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] line_addr(logic [17:0] tg, logic [5:0] st,
                                            logic [1:0] bk);
    return {tg, st, bk, 6'b0};
  endfunction

  function automatic void promote_way(int s, int w);
    int old;
    old = line_vld[s][w] ? line_rk[s][w] : 4;
    for (int i = 0; i < 4; i++)
      if (i != w && line_vld[s][i] && line_rk[s][i] < old && line_rk[s][i] < 3)
        line_rk[s][i]++;
    line_rk[s][w] = 0;
  endfunction

  // work out the results of one access and update the mirror
  function automatic void predict_lookup(access_t a);
    tag_result_t r;
    logic [1:0]  bk;
    logic [5:0]  st;
    logic [17:0] tg;
    int          s, found, n, v;
    bk = a.address[7:6];
    st = a.address[13:8];
    tg = a.address[31:14];
    s = {bk, st};
    r = '0;
    r.bank = bk;
    r.set_idx = st;
    r.last = 1'b1;
    found = 4;
    if (bypass_q) begin
      r.bypassed = 1'b1;
      expected_results.push_back(r);
      return;
    end
    if (a.mode inside {blcta_pkg::MODE_READ, blcta_pkg::MODE_WRITE} &&
        a.address[5:0] != 0) begin
      r.misaligned = 1'b1;
      expected_results.push_back(r);
      return;
    end
    if (a.mode == blcta_pkg::MODE_CLEAN) begin
      n = 0;
      for (int w = 0; w < 4; w++)
        if (line_vld[s][w] && line_drt[s][w]) begin
          if (n > 0) begin
            r.last = 1'b0;
            expected_results.push_back(r);
          end
          line_drt[s][w] = 1'b0;
          r.way = w;
          r.writeback = 1'b1;
          r.writeback_address = line_addr(line_tg[s][w], st, bk);
          n++;
        end
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    for (int w = 0; w < 4; w++)
      if (found == 4 && line_vld[s][w] && line_tg[s][w] == tg) found = w;
    if (a.mode == blcta_pkg::MODE_INVAL) begin
      if (found != 4) begin
        r.hit = 1'b1;
        r.way = found;
        r.writeback = line_drt[s][found];
        if (r.writeback) r.writeback_address = {a.address[31:6], 6'b0};
        for (int w = 0; w < 4; w++)
          if (w != found && line_vld[s][w] && line_rk[s][w] > line_rk[s][found])
            line_rk[s][w]--;
        line_vld[s][found] = 1'b0;
        line_drt[s][found] = 1'b0;
        line_rk[s][found] = 0;
      end
      expected_results.push_back(r);
      return;
    end
    if (found != 4) begin
      promote_way(s, found);
      if (a.mode == blcta_pkg::MODE_WRITE) line_drt[s][found] = 1'b1;
      r.hit = 1'b1;
      r.way = found;
      expected_results.push_back(r);
      return;
    end
    // miss: lowest invalid way, else highest rank
    v = 4;
    for (int w = 0; w < 4; w++)
      if (v == 4 && !line_vld[s][w]) v = w;
    if (v == 4) begin
      v = 0;
      for (int w = 1; w < 4; w++)
        if (line_rk[s][w] > line_rk[s][v]) v = w;
    end
    r.way = v;
    r.evicted = line_vld[s][v];
    r.writeback = line_vld[s][v] && line_drt[s][v];
    if (r.writeback) r.writeback_address = line_addr(line_tg[s][v], st, bk);
    r.fetch_needed = !(a.mode == blcta_pkg::MODE_WRITE && a.full_line);
    promote_way(s, v);
    line_vld[s][v] = 1'b1;
    line_drt[s][v] = (a.mode == blcta_pkg::MODE_WRITE);
    line_tg[s][v] = tg;
    expected_results.push_back(r);
  endfunction

  // driver: one item at a time from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= blcta_pkg::MODE_READ;
      address_i <= '0;
      full_line_i <= 1'b0;
      send_gap <= 0;
    end else if (in_valid_i && !in_ready_o) begin
      // hold the item
    end else if (in_valid_i || send_gap == 0) begin
      if (in_valid_i && !no_idle && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        send_gap <= $urandom_range(1, 3);
      end else if (pending_accesses.size() > 0) begin
        access_t a;
        a = pending_accesses.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= a.mode;
        address_i <= a.address;
        full_line_i <= a.full_line;
      end else begin
        in_valid_i <= 1'b0;
      end
    end else begin
      send_gap <= send_gap - 1;
    end
  end

  // monitor: check results, then predict newly accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      tag_result_t got, exp_r;
      access_t acc;
      cycles++;
      if (out_valid_o && out_ready_i) begin
        got = '{hit_o, way_o, bank_o, set_idx_o, evicted_o, writeback_o,
                writeback_address_o, fetch_needed_o, bypassed_o, misaligned_o,
                last_o};
        result_cnt++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            errors++;
          end
          hit_cnt += exp_r.hit;
          evict_cnt += exp_r.evicted;
          wb_cnt += exp_r.writeback;
        end
      end
      if (in_valid_i && in_ready_o) begin
        acc = '{blcta_pkg::mode_e'(mode_i), address_i, full_line_i};
        predict_lookup(acc);
        accepted++;
      end
      // receiver stalls
      if (out_valid_o && out_ready_i || recv_stall == 0) begin
        if (!no_idle && $urandom_range(0, 2) == 0) begin
          out_ready_i <= 1'b0;
          recv_stall <= $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b1;
        end
      end else begin
        recv_stall <= recv_stall - 1;
        out_ready_i <= (recv_stall == 1);
      end
      if (cycles > CycleLimit) begin
        $display("banked_lru_cache_tag_array verification failed");
        $finish;
      end
    end
  end

  task automatic queue_access(blcta_pkg::mode_e m, logic [31:0] a, logic f);
    pending_accesses.push_back('{m, a, f});
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_accesses.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bypass(logic v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bypass_q = v;
  endtask

  // random access focused on a few sets and tags to exercise lru
  task automatic queue_random(int n);
    logic [31:0] a;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      a = {$urandom_range(0, 5) == 0 ? 18'($urandom) : 18'($urandom_range(0, 5)),
           6'($urandom_range(0, 1)), 2'($urandom_range(0, 1)), 6'b0};
      if (k == 0) a = $urandom;
      else if (k == 1) a[5:0] = 6'($urandom);
      queue_access(blcta_pkg::mode_e'($urandom_range(0, 9) < 7 ? $urandom_range(0, 1)
                                                               : $urandom_range(2, 3)),
                   a, 1'($urandom_range(0, 1)));
    end
  endtask

  // stimulus
  initial begin
    errors = 0; accepted = 0; result_cnt = 0; hit_cnt = 0; evict_cnt = 0;
    wb_cnt = 0; cycles = 0; no_idle = 0; bypass_q = 0;
    cfg_we_i = 0; cfg_wdata_i = 0;
    for (int s = 0; s < 256; s++)
      for (int w = 0; w < 4; w++) begin
        line_vld[s][w] = 0; line_drt[s][w] = 0; line_tg[s][w] = 0; line_rk[s][w] = 0;
      end
    rst_ni = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_bypass(1'b0);

    // directed: fill a set, evict, dirty paths, invalidate and clean, misaligned accesses
    for (int t = 0; t < 4; t++)
      queue_access(blcta_pkg::MODE_READ, {18'(t), 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_WRITE, {18'd1, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_WRITE, {18'd9, 6'd5, 2'd1, 6'd0}, 1'b1);
    queue_access(blcta_pkg::MODE_WRITE, {18'd10, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_READ, {18'd11, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_INVAL, {18'd1, 6'd5, 2'd1, 6'd17}, 1'b0);
    queue_access(blcta_pkg::MODE_INVAL, {18'd77, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_WRITE, {18'd3, 6'd5, 2'd1, 6'd0}, 1'b1);
    queue_access(blcta_pkg::MODE_CLEAN, {18'h3ffff, 6'd5, 2'd1, 6'h3f}, 1'b0);
    queue_access(blcta_pkg::MODE_CLEAN, {18'd0, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_READ, 32'h0000_0001, 1'b0);
    queue_access(blcta_pkg::MODE_WRITE, 32'hffff_ffe0, 1'b1);
    queue_access(blcta_pkg::MODE_WRITE, 32'hffff_ffc0, 1'b1);
    queue_access(blcta_pkg::MODE_READ, 32'h0000_0000, 1'b0);
    queue_access(blcta_pkg::MODE_INVAL, 32'hffff_ffff, 1'b0);
    queue_access(blcta_pkg::MODE_CLEAN, 32'hffff_ffff, 1'b0);
    wait_drained();

    // random with idling, a pause for full drain, then random without idling
    queue_random(30);
    wait_drained();
    no_idle = 1;
    queue_random(20);
    wait_drained();
    no_idle = 0;

    // bypass on: every mode passes through
    write_bypass(1'b1);
    queue_access(blcta_pkg::MODE_READ, 32'h0000_0041, 1'b0);
    queue_access(blcta_pkg::MODE_WRITE, {18'd1, 6'd5, 2'd1, 6'd0}, 1'b1);
    queue_access(blcta_pkg::MODE_INVAL, {18'd3, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_access(blcta_pkg::MODE_CLEAN, {18'd0, 6'd5, 2'd1, 6'd0}, 1'b0);
    queue_random(8);
    wait_drained();

    // bypass off again: state must be intact
    write_bypass(1'b0);
    queue_random(20);
    wait_drained();

    $display("covered %0d accesses, %0d results: %0d hits, %0d evictions, %0d write-backs",
             accepted, result_cnt, hit_cnt, evict_cnt, wb_cnt);
    $display("bypass toggled on and off, with and without handshake idling");
    if (errors == 0) begin
      $display("banked_lru_cache_tag_array verification clean");
    end else begin
      $display("banked_lru_cache_tag_array verification failed");
    end
    $finish;
  end
endmodule
